### hdl/rgbf_pkg.sv
`default_nettype none

package rgbf_pkg;

  localparam int IMG_W     = 640;
  localparam int IMG_H     = 480;
  localparam int COL_W     = $clog2(IMG_W);
  localparam int ROW_W     = $clog2(IMG_H + 2);
  localparam int CH_W      = 8;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 9;
  localparam int SUM_W     = 11;
  localparam int DIV9_MUL  = 7282;
  localparam int DIV9_MW   = 13;
  localparam int DIV9_SH   = 16;
  localparam int CH_MAX    = 170;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_PAD   = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } rgbf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]      red_out;
    logic [CH_W-1:0]      green_out;
    logic [CH_W-1:0]      blue_out;
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row;
    logic                 frame_end;
  } rgbf_out_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sums_t;

  function automatic logic [SUM_W-1:0] chan_sum(
    input logic [CH_W-1:0] up,
    input logic [CH_W-1:0] dn,
    input logic [CH_W-1:0] lf,
    input logic [CH_W-1:0] rt,
    input logic [CH_W-1:0] ce
  );
    return SUM_W'(up) + SUM_W'(dn) + SUM_W'(lf) + SUM_W'(rt) + SUM_W'({ce, 1'b0});
  endfunction

  // reciprocal multiply, exact for sums up to six full-scale channels
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_MW-1:0] p;
    p = (SUM_W + DIV9_MW)'(s) * (SUM_W + DIV9_MW)'(DIV9_MUL);
    return p[DIV9_SH +: CH_W];
  endfunction

endpackage

`default_nettype wire

### hdl/rgbf_ram.sv
`default_nettype none

module rgbf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/rgbf_cell.sv
`default_nettype none

module rgbf_cell
  import rgbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire col_t col_in,
  output col_t      col_out
);

  col_t col_r;
  col_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

### hdl/rgb_3x3_kernel_filter.sv
`default_nettype none

// Streaming 3x3 filter over a 640x480 RGB raster: per channel (up + down + left
// + right + 2*centre) / 9, truncated, with zero outside the frame. Takes one
// pixel per clock while the output skid stage is empty; output trails input by
// 641 positions, so 641 padding transfers after the frame flush the last row.
// A result passes from the input transfer that completes its neighbourhood
// through the line-store read (s1), the window column cells and the sums (s2)
// and the divide by 9 into the output register. The two line stores share one
// 640-entry memory, read at acceptance and written back from the s1 stage.
module rgb_3x3_kernel_filter
  import rgbf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rgbf_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rgbf_out_t      out_data
);

  logic en;
  logic acc;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_in;
  pixel_t           v_in;

  logic             s1_valid_r;
  pixel_t           s1_v_r;
  logic [COL_W-1:0] s1_x_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             byp_r;
  line_t            byp_data_r;
  logic             byp_nxt;

  line_t            ram_rd;
  line_t            entry;
  line_t            wr_data;
  logic             wr_en;
  pixel_t           top, mid;

  col_t             cell_in, w2, w1;
  logic             shift_en;

  logic             emit;
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic             last;
  pixel_t           up, dn, lf, rt, ce;
  sums_t            sums;

  logic             s2_valid_r;
  sums_t            s2_sums_r;
  logic [COL_W-1:0] s2_cx_r;
  logic [ROW_W-1:0] s2_cy_r;
  logic             s2_last_r;
  rgbf_out_t        res;

  rgbf_out_t        out_r, skid_r;
  logic             out_valid_r, skid_full_r;

  assign en       = !skid_full_r;
  assign in_ready = en;
  assign acc      = in_valid && en;

  // input position
  always_comb begin
    last_in = (col_r == '0) && (row_r == ROW_W'(IMG_H + 1));
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_in) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == COL_W'(IMG_W - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    if (in_data.req_type == REQ_PAD) begin
      v_in = '0;
    end else begin
      v_in = pixel_t'{in_data.red_in, in_data.green_in, in_data.blue_in};
    end
  end

  // line stores
  assign wr_en   = s1_valid_r && en;
  assign byp_nxt = wr_en && (s1_x_r == col_r);

  rgbf_ram #(
    .DATA_W ($bits(line_t)),
    .DEPTH  (IMG_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_x_r),
    .wdata (wr_data),
    .re    (acc),
    .raddr (col_r),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_v_r     <= v_in;
      s1_x_r     <= col_r;
      s1_row_r   <= row_r;
      byp_r      <= byp_nxt;
      byp_data_r <= wr_data;
    end
  end

  always_comb begin
    entry   = byp_r ? byp_data_r : ram_rd;
    top     = entry.older;
    mid     = entry.newer;
    wr_data = line_t'{mid, s1_v_r};
  end

  // window column cells
  assign shift_en = s1_valid_r && en;
  assign cell_in  = col_t'{top, mid, s1_v_r};

  rgbf_cell u_cell_new (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .col_in   (cell_in),
    .col_out  (w2)
  );

  rgbf_cell u_cell_old (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .col_in   (w2),
    .col_out  (w1)
  );

  // centre position and edge masks
  always_comb begin
    emit = (s1_row_r >= ROW_W'(2)) || ((s1_row_r == ROW_W'(1)) && (s1_x_r != '0));
    if (s1_x_r == '0) begin
      cx = COL_W'(IMG_W - 1);
      cy = s1_row_r - ROW_W'(2);
    end else begin
      cx = s1_x_r - 1'b1;
      cy = s1_row_r - ROW_W'(1);
    end
    last = (cx == COL_W'(IMG_W - 1)) && (cy == ROW_W'(IMG_H - 1));
    up   = (cy == '0) ? '0 : w2.top;
    dn   = (cy == ROW_W'(IMG_H - 1)) ? '0 : w2.bot;
    lf   = (cx == '0) ? '0 : w1.mid;
    rt   = (cx == COL_W'(IMG_W - 1)) ? '0 : mid;
    ce   = w2.mid;
    sums.r = chan_sum(up.r, dn.r, lf.r, rt.r, ce.r);
    sums.g = chan_sum(up.g, dn.g, lf.g, rt.g, ce.g);
    sums.b = chan_sum(up.b, dn.b, lf.b, rt.b, ce.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sums_r <= sums;
      s2_cx_r   <= cx;
      s2_cy_r   <= cy;
      s2_last_r <= last;
    end
  end

  always_comb begin
    res.red_out   = div9(s2_sums_r.r);
    res.green_out = div9(s2_sums_r.g);
    res.blue_out  = div9(s2_sums_r.b);
    res.column    = OUT_COL_W'(s2_cx_r);
    res.row       = OUT_ROW_W'(s2_cy_r);
    res.frame_end = s2_last_r;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ready) begin
        skid_full_r <= 1'b0;
      end
    end else if (s2_valid_r) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (s2_valid_r) begin
      if (!out_valid_r || out_ready) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hdl/rgbf_checker.sv
`default_nettype none

module rgbf_checker
  import rgbf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire rgbf_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire rgbf_out_t out_data
);

  logic out_xfer;
  logic in_xfer;

  assign out_xfer = out_valid && out_ready;
  assign in_xfer  = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_result_early: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present straight after reset");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_data.frame_end |->
      out_data.column == OUT_COL_W'(IMG_W - 1) && out_data.row == OUT_ROW_W'(IMG_H - 1))
    else $error("frame end on wrong pixel");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_data.red_out <= CH_W'(CH_MAX) && out_data.green_out <= CH_W'(CH_MAX)
      && out_data.blue_out <= CH_W'(CH_MAX) && out_data.column <= OUT_COL_W'(IMG_W - 1)
      && out_data.row <= OUT_ROW_W'(IMG_H - 1))
    else $error("result out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_xfer || !in_ready, 3))
    else $error("result with no input transfer behind it");

endmodule

bind rgb_3x3_kernel_filter rgbf_checker u_rgbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### test/rgb_3x3_kernel_filter_test.sv
`default_nettype none

module rgb_3x3_kernel_filter_test;
  import rgbf_pkg::*;

  localparam int CYCLE_LIMIT    = 2000000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int SHOWN_ERRORS   = 10;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PIX_W          = $bits(pixel_t);

  typedef enum {STYLE_NOISE, STYLE_WHITE, STYLE_BLACK, STYLE_FLAT} run_style_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  rgbf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rgbf_out_t out_data;

  rgb_3x3_kernel_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // model of the filter state
  pixel_t line_older [IMG_W];
  pixel_t line_newer [IMG_W];
  pixel_t nbhd [3][3];
  int     pos_col;
  int     pos_row;

  rgbf_out_t filtered_due [$];

  int          fail_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holdoff_req = 0;
  int unsigned holdoff_ack = 0;
  int unsigned holdoff_left = 0;
  run_style_t  run_style;
  pixel_t      run_colour;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rgb_3x3_kernel_filter");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [CH_W-1:0] weighted_mean(input logic [CH_W-1:0] up, dn, lf, rt,
                                                    ce);
    int s;
    s = int'(up) + int'(dn) + int'(lf) + int'(rt) + 2 * int'(ce);
    return CH_W'(s / 9);
  endfunction

  function automatic void filter_pixel(input rgbf_in_t item);
    pixel_t    px, top, mid, up, dn, lf, rt, ce;
    int        x, cx, cy;
    bit        last;
    rgbf_out_t res;
    x = pos_col;
    px = (item.req_type == REQ_PAD) ? pixel_t'('0)
                                    : pixel_t'({item.red_in, item.green_in, item.blue_in});
    top = line_older[x];
    mid = line_newer[x];
    line_older[x] = mid;
    line_newer[x] = px;
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = top;
    nbhd[1][2] = mid;
    nbhd[2][2] = px;
    last = 1'b0;
    if (pos_row >= 2 || (pos_row == 1 && x >= 1)) begin
      if (x == 0) begin
        cx = IMG_W - 1;
        cy = pos_row - 2;
      end else begin
        cx = x - 1;
        cy = pos_row - 1;
      end
      last = (cx == IMG_W - 1 && cy == IMG_H - 1);
      // zero padding outside the frame
      up = (cy == 0) ? pixel_t'('0) : nbhd[0][1];
      dn = (cy == IMG_H - 1) ? pixel_t'('0) : nbhd[2][1];
      lf = (cx == 0) ? pixel_t'('0) : nbhd[1][0];
      rt = (cx == IMG_W - 1) ? pixel_t'('0) : nbhd[1][2];
      ce = nbhd[1][1];
      res.red_out   = weighted_mean(up.r, dn.r, lf.r, rt.r, ce.r);
      res.green_out = weighted_mean(up.g, dn.g, lf.g, rt.g, ce.g);
      res.blue_out  = weighted_mean(up.b, dn.b, lf.b, rt.b, ce.b);
      res.column    = OUT_COL_W'(cx);
      res.row       = OUT_ROW_W'(cy);
      res.frame_end = last;
      filtered_due.push_back(res);
    end
    if (last) begin
      pos_col = 0;
      pos_row = 0;
    end else begin
      pos_col = x + 1;
      if (pos_col >= IMG_W) begin
        pos_col = 0;
        pos_row++;
      end
    end
  endfunction

  always @(posedge clk) begin
    rgbf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (filtered_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
          $display("unexpected result: rgb %0d %0d %0d at (%0d,%0d) end %b",
                   out_data.red_out, out_data.green_out, out_data.blue_out,
                   out_data.column, out_data.row, out_data.frame_end);
      end else begin
        want = filtered_due.pop_front();
        if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
            out_data.blue_out !== want.blue_out || out_data.column !== want.column ||
            out_data.row !== want.row || out_data.frame_end !== want.frame_end) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS) begin
            $display("mismatch: want rgb %0d %0d %0d at (%0d,%0d) end %b",
                     want.red_out, want.green_out, want.blue_out,
                     want.column, want.row, want.frame_end);
            $display("          got  rgb %0d %0d %0d at (%0d,%0d) end %b",
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.column, out_data.row, out_data.frame_end);
          end
        end
      end
    end
  end

  function automatic logic [CH_W-1:0] chan_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // runs of flat colour so that full-scale neighbourhoods turn up
  function automatic rgbf_in_t gen_item(input int unsigned pad_pct);
    rgbf_in_t it;
    if ($urandom_range(0, 63) == 0) begin
      run_style  = run_style_t'($urandom_range(0, 3));
      run_colour = pixel_t'(PIX_W'($urandom));
    end
    case (run_style)
      STYLE_WHITE: {it.red_in, it.green_in, it.blue_in} = '1;
      STYLE_BLACK: {it.red_in, it.green_in, it.blue_in} = '0;
      STYLE_FLAT:  {it.red_in, it.green_in, it.blue_in} = run_colour;
      default: begin
        it.red_in   = chan_value();
        it.green_in = chan_value();
        it.blue_in  = chan_value();
      end
    endcase
    it.req_type = ($urandom_range(0, 99) < pad_pct) ? REQ_PAD : REQ_PIXEL;
    return it;
  endfunction

  task automatic push_pixel(input rgbf_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_pixel(item);
  endtask

  task automatic test_directed_extremes();
    rgbf_in_t pattern [24] = '{
      '{REQ_PIXEL, 8'h00, 8'h00, 8'h00}, '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF},
      '{REQ_PIXEL, 8'hFF, 8'h00, 8'h00}, '{REQ_PIXEL, 8'h00, 8'hFF, 8'h00},
      '{REQ_PIXEL, 8'h00, 8'h00, 8'hFF}, '{REQ_PIXEL, 8'hAA, 8'h55, 8'hAA},
      '{REQ_PIXEL, 8'h55, 8'hAA, 8'h55}, '{REQ_PAD,   8'hFF, 8'hFF, 8'hFF},
      '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF}, '{REQ_PIXEL, 8'h01, 8'h80, 8'hFE},
      '{REQ_PAD,   8'h00, 8'h00, 8'h00}, '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF},
      '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF}, '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF},
      '{REQ_PIXEL, 8'h00, 8'h00, 8'h00}, '{REQ_PIXEL, 8'hFF, 8'h00, 8'hFF},
      '{REQ_PAD,   8'hAA, 8'h55, 8'hAA}, '{REQ_PIXEL, 8'h7F, 8'h80, 8'h7F},
      '{REQ_PIXEL, 8'h80, 8'h7F, 8'h80}, '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF},
      '{REQ_PIXEL, 8'hFE, 8'h01, 8'hFE}, '{REQ_PIXEL, 8'h00, 8'hFF, 8'h00},
      '{REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF}, '{REQ_PIXEL, 8'h00, 8'h00, 8'h00}
    };
    send_idle_pct = 9;
    recv_idle_pct = 69;
    foreach (pattern[i]) push_pixel(pattern[i]);
  endtask

  task automatic test_random_first_rows();
    send_idle_pct = 9;
    recv_idle_pct = 69;
    repeat (700) push_pixel(gen_item(3));
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 69;
    recv_idle_pct = 9;
    holdoff_req <= holdoff_req + 1;
    repeat (150) push_pixel(gen_item(3));
  endtask

  task automatic test_sender_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (filtered_due.size() != 0);
  endtask

  task automatic test_random_swapped_idling();
    send_idle_pct = 69;
    recv_idle_pct = 9;
    repeat (326) push_pixel(gen_item(3));
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (350) push_pixel(gen_item(3));
  endtask

  initial begin
    foreach (line_older[i]) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    foreach (nbhd[i, j]) nbhd[i][j] = '0;
    pos_col       = 0;
    pos_row       = 0;
    send_idle_pct = 9;
    recv_idle_pct = 69;
    run_style     = STYLE_NOISE;
    run_colour    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_first_rows();
    test_output_holdoff();
    test_sender_pause();
    test_random_swapped_idling();
    test_no_idling();
    in_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS rgb_3x3_kernel_filter");
    else
      $display("FAIL rgb_3x3_kernel_filter");
    $finish;
  end

endmodule

`default_nettype wire
